### sv/csc_pkg.sv
package csc_pkg;

    // input request: reading kind and raw converter value
    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] raw_adc;
    } csc_in_t;

    // compensated result
    typedef struct packed {
        logic signed [31:0] value;
        logic               zero_divisor;
    } csc_out_t;

    // reading kinds
    localparam logic [1:0] KIND_TEMP   = 2'd0;
    localparam logic [1:0] KIND_PRESS  = 2'd1;
    localparam logic [1:0] KIND_HUM    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_TRIM    = 3'd0;
    localparam logic [2:0] REG_PRESS_TRIM_A = 3'd1;
    localparam logic [2:0] REG_PRESS_TRIM_B = 3'd2;
    localparam logic [2:0] REG_PRESS_TRIM_C = 3'd3;
    localparam logic [2:0] REG_HUM_TRIM     = 3'd4;

    // compensation constants
    localparam logic [31:0] C_64000     = 32'd64000;
    localparam logic [31:0] C_1048576   = 32'd1048576;
    localparam logic [31:0] C_3125      = 32'd3125;
    localparam logic [31:0] C_76800     = 32'd76800;
    localparam logic [31:0] C_HUM_MAX   = 32'd419430400;
    localparam logic [31:0] C_16384     = 32'd16384;
    localparam logic [31:0] C_2097152   = 32'd2097152;
    localparam logic [31:0] C_8192      = 32'd8192;
    localparam logic [31:0] C_32768     = 32'd32768;
    localparam logic [31:0] C_128       = 32'd128;
    localparam logic [31:0] C_5         = 32'd5;
    localparam logic [31:0] C_25        = 32'd25;

    // arithmetic right shift of a 32-bit pattern
    function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
        return $unsigned($signed(x) >>> n);
    endfunction

    // sign extension of trim fields
    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

### sv/csc_div.sv
module csc_div import csc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic [4:0]  count_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] div_reg;
    logic        done_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_diff;

    // one restoring step per cycle
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
                rem_reg   <= '0;
                quo_reg   <= dividend;
                div_reg   <= divisor;
            end else if (busy_reg) begin
                if (!rem_diff[32]) begin
                    rem_reg <= rem_diff[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/climate_sensor_compensation.sv
// Integer compensation of temperature, pressure and humidity readings with trim
// coefficients held in APB registers (8-byte stride, 64-bit data). One request is
// worked at a time through a single shared 32x32 multiplier under a sequencer.
// Temperature has the shortest sequence and pressure the longest, since pressure
// waits on the bit-serial divider; a zero divisor is caught before the divider
// starts and returns early with zero_divisor set. A temperature request updates
// the stored fine temperature used by later pressure and humidity requests. A new
// request is taken once the previous result has been collected.
module climate_sensor_compensation import csc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  csc_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output csc_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [5:0] {
        IDLE,
        T0, T1, T2, T3, T4, T5,
        P0, P1, P2, P3, P4, P5, P6, P7, P8, P9, P10, P11, PWAIT, P13, P14, P15, P16,
        H0, H1, H2, H3, H4, H5, H6, H7, H8, H9, H10, H11, H12, H13,
        DONE
    } state_t;

    state_t      state_reg;
    logic [47:0] temp_trim_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;
    logic [63:0] hum_trim_reg;
    logic [31:0] fine_reg;
    logic [19:0] adc_reg;
    logic [31:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic        m_valid_reg;
    csc_out_t    m_data_reg;

    logic [31:0] mul_a, mul_b, prod;
    logic [31:0] adc32, r_clamp, r_hum;
    logic        div_start, div_done;
    logic [31:0] div_quo;
    logic        wr_en;

    // trim coefficients
    logic [31:0] ct1, ct2, ct3;
    logic [31:0] cp1, cp2, cp3, cp4, cp5, cp6, cp7, cp8, cp9;
    logic [31:0] ch1, ch2, ch3, ch4, ch5, ch6;

    assign ct1 = {16'd0, temp_trim_reg[15:0]};
    assign ct2 = sx16(temp_trim_reg[31:16]);
    assign ct3 = sx16(temp_trim_reg[47:32]);
    assign cp1 = {16'd0, press_a_reg[15:0]};
    assign cp2 = sx16(press_a_reg[31:16]);
    assign cp3 = sx16(press_a_reg[47:32]);
    assign cp4 = sx16(press_a_reg[63:48]);
    assign cp5 = sx16(press_b_reg[15:0]);
    assign cp6 = sx16(press_b_reg[31:16]);
    assign cp7 = sx16(press_b_reg[47:32]);
    assign cp8 = sx16(press_b_reg[63:48]);
    assign cp9 = sx16(press_c_reg);
    assign ch1 = {24'd0, hum_trim_reg[7:0]};
    assign ch2 = sx16(hum_trim_reg[23:8]);
    assign ch3 = {24'd0, hum_trim_reg[31:24]};
    assign ch4 = sx12(hum_trim_reg[43:32]);
    assign ch5 = sx12(hum_trim_reg[55:44]);
    assign ch6 = sx8(hum_trim_reg[63:56]);

    assign adc32 = {12'd0, adc_reg};

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg <= '0;
            press_a_reg   <= '0;
            press_b_reg   <= '0;
            press_c_reg   <= '0;
            hum_trim_reg  <= '0;
        end else if (wr_en) begin
            unique case (paddr[5:3])
                REG_TEMP_TRIM:    temp_trim_reg <= pwdata[47:0];
                REG_PRESS_TRIM_A: press_a_reg   <= pwdata;
                REG_PRESS_TRIM_B: press_b_reg   <= pwdata;
                REG_PRESS_TRIM_C: press_c_reg   <= pwdata[15:0];
                REG_HUM_TRIM:     hum_trim_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_TEMP_TRIM:    prdata = {16'd0, temp_trim_reg};
            REG_PRESS_TRIM_A: prdata = press_a_reg;
            REG_PRESS_TRIM_B: prdata = press_b_reg;
            REG_PRESS_TRIM_C: prdata = {48'd0, press_c_reg};
            REG_HUM_TRIM:     prdata = hum_trim_reg;
            default:          prdata = '0;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            T0: begin
                mul_a = (adc32 >> 3) - (ct1 << 1);
                mul_b = ct2;
            end
            T1: begin
                mul_a = (adc32 >> 4) - ct1;
                mul_b = (adc32 >> 4) - ct1;
            end
            T2: begin
                mul_a = sra(t1_reg, 5'd12);
                mul_b = ct3;
            end
            T4: begin
                mul_a = fine_reg;
                mul_b = C_5;
            end
            P1: begin
                mul_a = sra(t0_reg, 5'd2);
                mul_b = sra(t0_reg, 5'd2);
            end
            P2: begin
                mul_a = sra(t1_reg, 5'd11);
                mul_b = cp6;
            end
            P3: begin
                mul_a = t0_reg;
                mul_b = cp5;
            end
            P5: begin
                mul_a = cp3;
                mul_b = sra(t1_reg, 5'd13);
            end
            P6: begin
                mul_a = cp2;
                mul_b = t0_reg;
            end
            P8: begin
                mul_a = C_32768 + t0_reg;
                mul_b = cp1;
            end
            P10: begin
                mul_a = (C_1048576 - adc32) - sra(t2_reg, 5'd12);
                mul_b = C_3125;
            end
            P13: begin
                mul_a = t1_reg >> 3;
                mul_b = t1_reg >> 3;
            end
            P14: begin
                mul_a = cp9;
                mul_b = t2_reg >> 13;
            end
            P15: begin
                mul_a = t1_reg >> 2;
                mul_b = cp8;
            end
            H1: begin
                mul_a = ch5;
                mul_b = t3_reg;
            end
            H3: begin
                mul_a = t3_reg;
                mul_b = ch6;
            end
            H4: begin
                mul_a = t3_reg;
                mul_b = ch3;
            end
            H5: begin
                mul_a = sra(t1_reg, 5'd10);
                mul_b = sra(t2_reg, 5'd11) + C_32768;
            end
            H6: begin
                mul_a = sra(t1_reg, 5'd10) + C_2097152;
                mul_b = ch2;
            end
            H8: begin
                mul_a = t0_reg;
                mul_b = t1_reg;
            end
            H9: begin
                mul_a = sra(t1_reg, 5'd15);
                mul_b = sra(t1_reg, 5'd15);
            end
            H10: begin
                mul_a = sra(t2_reg, 5'd7);
                mul_b = ch1;
            end
            H12: begin
                mul_a = t1_reg >> 12;
                mul_b = C_25;
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // humidity clamp
    assign r_hum   = t1_reg - sra(t2_reg, 5'd4);
    assign r_clamp = r_hum[31] ? 32'd0 : ((r_hum > C_HUM_MAX) ? C_HUM_MAX : r_hum);

    // divider for the pressure quotient
    assign div_start = (state_reg == P11);

    csc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (t1_reg[31] ? t1_reg : {t1_reg[30:0], 1'b0}),
        .divisor  (t0_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            fine_reg    <= '0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (s_valid && s_ready) begin
                        adc_reg <= s_data.raw_adc;
                        unique case (s_data.kind)
                            KIND_TEMP:  state_reg <= T0;
                            KIND_PRESS: state_reg <= P0;
                            KIND_HUM: begin
                                adc_reg   <= {4'd0, s_data.raw_adc[15:0]};
                                state_reg <= H0;
                            end
                            default: begin
                                m_data_reg  <= '{value: '0, zero_divisor: 1'b0};
                                m_valid_reg <= 1'b1;
                                state_reg   <= DONE;
                            end
                        endcase
                    end
                end
                // temperature
                T0: begin t0_reg <= prod; state_reg <= T1; end
                T1: begin t1_reg <= prod; state_reg <= T2; end
                T2: begin t1_reg <= prod; state_reg <= T3; end
                T3: begin
                    fine_reg  <= sra(t0_reg, 5'd11) + sra(t1_reg, 5'd14);
                    state_reg <= T4;
                end
                T4: begin t0_reg <= prod; state_reg <= T5; end
                T5: begin
                    m_data_reg  <= '{value: sra(t0_reg + C_128, 5'd8), zero_divisor: 1'b0};
                    m_valid_reg <= 1'b1;
                    state_reg   <= DONE;
                end
                // pressure
                P0: begin t0_reg <= sra(fine_reg, 5'd1) - C_64000; state_reg <= P1; end
                P1: begin t1_reg <= prod; state_reg <= P2; end
                P2: begin t2_reg <= prod; state_reg <= P3; end
                P3: begin t3_reg <= prod; state_reg <= P4; end
                P4: begin
                    t2_reg    <= sra(t2_reg + (t3_reg << 1), 5'd2) + (cp4 << 16);
                    state_reg <= P5;
                end
                P5: begin t3_reg <= prod; state_reg <= P6; end
                P6: begin t1_reg <= prod; state_reg <= P7; end
                P7: begin
                    t0_reg    <= sra(sra(t3_reg, 5'd3) + sra(t1_reg, 5'd1), 5'd18);
                    state_reg <= P8;
                end
                P8: begin t0_reg <= prod; state_reg <= P9; end
                P9: begin
                    t0_reg <= sra(t0_reg, 5'd15);
                    if (sra(t0_reg, 5'd15) == 32'd0) begin
                        m_data_reg  <= '{value: '0, zero_divisor: 1'b1};
                        m_valid_reg <= 1'b1;
                        state_reg   <= DONE;
                    end else begin
                        state_reg <= P10;
                    end
                end
                P10: begin t1_reg <= prod; state_reg <= P11; end
                P11: state_reg <= PWAIT;
                PWAIT: begin
                    if (div_done) begin
                        t1_reg    <= t1_reg[31] ? {div_quo[30:0], 1'b0} : div_quo;
                        state_reg <= P13;
                    end
                end
                P13: begin t2_reg <= prod; state_reg <= P14; end
                P14: begin t2_reg <= prod; state_reg <= P15; end
                P15: begin t3_reg <= prod; state_reg <= P16; end
                P16: begin
                    m_data_reg <= '{value: t1_reg + sra(sra(t2_reg, 5'd12)
                                   + sra(t3_reg, 5'd13) + cp7, 5'd4), zero_divisor: 1'b0};
                    m_valid_reg <= 1'b1;
                    state_reg   <= DONE;
                end
                // humidity
                H0: begin t3_reg <= fine_reg - C_76800; state_reg <= H1; end
                H1: begin t0_reg <= prod; state_reg <= H2; end
                H2: begin
                    t0_reg <= sra((adc32 << 14) - (ch4 << 20) - t0_reg + C_16384, 5'd15);
                    state_reg <= H3;
                end
                H3: begin t1_reg <= prod; state_reg <= H4; end
                H4: begin t2_reg <= prod; state_reg <= H5; end
                H5: begin t1_reg <= prod; state_reg <= H6; end
                H6: begin t1_reg <= prod; state_reg <= H7; end
                H7: begin t1_reg <= sra(t1_reg + C_8192, 5'd14); state_reg <= H8; end
                H8: begin t1_reg <= prod; state_reg <= H9; end
                H9: begin t2_reg <= prod; state_reg <= H10; end
                H10: begin t2_reg <= prod; state_reg <= H11; end
                H11: begin t1_reg <= r_clamp; state_reg <= H12; end
                H12: begin t1_reg <= prod; state_reg <= H13; end
                H13: begin
                    m_data_reg  <= '{value: t1_reg >> 8, zero_divisor: 1'b0};
                    m_valid_reg <= 1'b1;
                    state_reg   <= DONE;
                end
                DONE: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
